[src/disc_box_intersection_core_defines.svh]
// Assertion macros for the disc and box intersection core.
// Taken in by the top level; relies on signals named clk and rst in the including scope.
`ifndef DISC_BOX_INTERSECTION_CORE_DEFINES_SVH
`define DISC_BOX_INTERSECTION_CORE_DEFINES_SVH

// Implication checked in the same cycle.
`define DBI_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Implication checked in the next cycle.
`define DBI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/dbi_pkg.sv]
// Shared constants, payload types and the arctangent table of the disc and box core.
// Used by dbi_cordic, dbi_sector and disc_box_intersection_core; depends on nothing.
package dbi_pkg;

  localparam int COORD_BITS       = 32;
  localparam int FRAC_BITS        = 16;
  localparam int CORDIC_ITERS     = 20;
  localparam int ANG_FRAC         = 30;
  localparam int AREA_BITS        = 50;
  localparam int ARC_BITS         = 35;
  localparam int CFG_BITS         = 32;
  localparam int CFG_IDX_BITS     = 3;
  localparam int SQ_BITS          = 2 * COORD_BITS;
  localparam int ANG_BITS         = 31;
  localparam int Z_BITS           = 33;
  localparam int CX_BITS          = COORD_BITS + 4;
  localparam int SHIFT_BITS       = 5;
  localparam int SQRT_PER_STAGE   = 2;
  localparam int SQRT_STAGES      = COORD_BITS / SQRT_PER_STAGE;
  localparam int CORDIC_PER_STAGE = 2;
  localparam int CORDIC_STAGES    = (CORDIC_ITERS + CORDIC_PER_STAGE - 1) / CORDIC_PER_STAGE;
  localparam int CORDIC_LAT       = CORDIC_STAGES + 3;
  localparam int SECTORS          = 8;
  localparam int SEQ_BITS         = 3;
  localparam int TERM_AREA_BITS   = AREA_BITS;
  localparam int TERM_ARC_BITS    = 33;
  localparam int ACC_AREA_BITS    = AREA_BITS + 4;
  localparam int ACC_ARC_BITS     = ARC_BITS + 1;
  localparam int FIFO_DEPTH       = 16;
  localparam int FIFO_AW          = 4;

  localparam logic [ANG_BITS-1:0] HALF_PI_Q30 = 31'h6487ED51;

  localparam logic [CFG_IDX_BITS-1:0] CFG_XMIN   = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_XMAX   = 3'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_YMIN   = 3'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_YMAX   = 3'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_RADIUS = 3'd4;

  localparam logic [CFG_BITS-1:0] XMIN_RESET   = 32'h0000_0000;
  localparam logic [CFG_BITS-1:0] XMAX_RESET   = 32'hFFFF_FFFF;
  localparam logic [CFG_BITS-1:0] YMIN_RESET   = 32'h0000_0000;
  localparam logic [CFG_BITS-1:0] YMAX_RESET   = 32'hFFFF_FFFF;
  localparam logic [CFG_BITS-1:0] RADIUS_RESET = 32'h0001_0000;

  typedef struct packed {
    logic [COORD_BITS-1:0] point_x;
    logic [COORD_BITS-1:0] point_y;
  } in_item_t;

  typedef struct packed {
    logic [AREA_BITS-1:0] area;
    logic [ARC_BITS-1:0]  arc_length;
    logic                 outside;
  } out_item_t;

  // Control that travels with every sector request.
  typedef struct packed {
    logic first;
    logic last;
    logic outside;
  } sec_tag_t;

  // Arctangent of 2^-s in Q0.30 radians.
  function automatic logic [ANG_FRAC-1:0] atan_q30(input logic [SHIFT_BITS-1:0] s);
    logic [ANG_FRAC-1:0] v;
    case (s)
      5'd0:    v = 30'h3243F6A8;
      5'd1:    v = 30'h1DAC6705;
      5'd2:    v = 30'h0FADBAFC;
      5'd3:    v = 30'h07F56EA6;
      5'd4:    v = 30'h03FEAB76;
      5'd5:    v = 30'h01FFD55B;
      5'd6:    v = 30'h00FFFAAA;
      5'd7:    v = 30'h007FFF55;
      5'd8:    v = 30'h003FFFEA;
      5'd9:    v = 30'h001FFFFD;
      5'd10:   v = 30'h000FFFFF;
      5'd11:   v = 30'h0007FFFF;
      5'd12:   v = 30'h0003FFFF;
      5'd13:   v = 30'h0001FFFF;
      5'd14:   v = 30'h0000FFFF;
      5'd15:   v = 30'h00007FFF;
      5'd16:   v = 30'h00003FFF;
      5'd17:   v = 30'h00001FFF;
      5'd18:   v = 30'h00000FFF;
      5'd19:   v = 30'h000007FF;
      5'd20:   v = 30'h000003FF;
      5'd21:   v = 30'h000001FF;
      5'd22:   v = 30'h000000FF;
      5'd23:   v = 30'h0000007F;
      5'd24:   v = 30'h0000003F;
      5'd25:   v = 30'h0000001F;
      5'd26:   v = 30'h0000000F;
      5'd27:   v = 30'h00000008;
      5'd28:   v = 30'h00000004;
      5'd29:   v = 30'h00000002;
      5'd30:   v = 30'h00000001;
      default: v = 30'h00000000;
    endcase
    return v;
  endfunction

endpackage

[src/dbi_cordic.sv]
// Pipelined CORDIC vectoring unit giving atan2(y, x) for non-negative operands, clamped to
// [0, pi/2] in Q1.30; normalisation, rotation and output stages registered; depends on dbi_pkg.
module dbi_cordic (
  input  logic                               clk,
  input  logic [dbi_pkg::COORD_BITS-1:0]     y,
  input  logic [dbi_pkg::COORD_BITS-1:0]     x,
  output logic [dbi_pkg::ANG_BITS-1:0]       angle
);

  // Normalisation stage.
  logic [dbi_pkg::COORD_BITS-1:0] nx, ny;
  logic [dbi_pkg::SHIFT_BITS-1:0] nk;
  logic                           nzero, nhalf;
  logic [dbi_pkg::SHIFT_BITS-1:0] k_next;

  // Rotation stages.
  logic signed [dbi_pkg::CX_BITS-1:0] cx_q [0:dbi_pkg::CORDIC_STAGES];
  logic signed [dbi_pkg::CX_BITS-1:0] cy_q [0:dbi_pkg::CORDIC_STAGES];
  logic signed [dbi_pkg::Z_BITS-1:0]  z_q  [0:dbi_pkg::CORDIC_STAGES];
  logic                               zf_q [0:dbi_pkg::CORDIC_STAGES];
  logic                               hf_q [0:dbi_pkg::CORDIC_STAGES];
  logic signed [dbi_pkg::CX_BITS-1:0] cx_next [0:dbi_pkg::CORDIC_STAGES-1];
  logic signed [dbi_pkg::CX_BITS-1:0] cy_next [0:dbi_pkg::CORDIC_STAGES-1];
  logic signed [dbi_pkg::Z_BITS-1:0]  z_next  [0:dbi_pkg::CORDIC_STAGES-1];

  logic [dbi_pkg::ANG_BITS-1:0] angle_next;

  // The operands are shifted up until the top bit of either reaches bit 31.
  always_comb begin
    logic [dbi_pkg::COORD_BITS-1:0] or_v;
    logic [dbi_pkg::SHIFT_BITS-1:0] msb;
    or_v = x | y;
    msb  = '0;
    for (int i = 0; i < dbi_pkg::COORD_BITS - 1; i++) begin
      if (or_v[i]) begin
        msb = dbi_pkg::SHIFT_BITS'(i);
      end
    end
    if (or_v[dbi_pkg::COORD_BITS-1]) begin
      k_next = '0;
    end else begin
      k_next = dbi_pkg::SHIFT_BITS'(dbi_pkg::COORD_BITS - 1) - msb;
    end
  end

  always_comb begin
    logic signed [dbi_pkg::CX_BITS-1:0] xt, yt, dx, dy;
    logic signed [dbi_pkg::Z_BITS-1:0]  zt, at;
    logic [dbi_pkg::SHIFT_BITS-1:0]     s;
    for (int st = 0; st < dbi_pkg::CORDIC_STAGES; st++) begin
      xt = cx_q[st];
      yt = cy_q[st];
      zt = z_q[st];
      for (int j = 0; j < dbi_pkg::CORDIC_PER_STAGE; j++) begin
        if (st * dbi_pkg::CORDIC_PER_STAGE + j < dbi_pkg::CORDIC_ITERS) begin
          s  = dbi_pkg::SHIFT_BITS'(st * dbi_pkg::CORDIC_PER_STAGE + j);
          dx = xt >>> s;
          dy = yt >>> s;
          at = dbi_pkg::Z_BITS'(dbi_pkg::atan_q30(s));
          if (!yt[dbi_pkg::CX_BITS-1]) begin
            xt = xt + dy;
            yt = yt - dx;
            zt = zt + at;
          end else begin
            xt = xt - dy;
            yt = yt + dx;
            zt = zt - at;
          end
        end
      end
      cx_next[st] = xt;
      cy_next[st] = yt;
      z_next[st]  = zt;
    end
  end

  always_comb begin
    logic signed [dbi_pkg::Z_BITS-1:0] zf;
    zf = z_q[dbi_pkg::CORDIC_STAGES];
    if (zf_q[dbi_pkg::CORDIC_STAGES]) begin
      angle_next = '0;
    end else if (hf_q[dbi_pkg::CORDIC_STAGES]) begin
      angle_next = dbi_pkg::HALF_PI_Q30;
    end else if (zf[dbi_pkg::Z_BITS-1]) begin
      angle_next = '0;
    end else if (zf > $signed(dbi_pkg::Z_BITS'(dbi_pkg::HALF_PI_Q30))) begin
      angle_next = dbi_pkg::HALF_PI_Q30;
    end else begin
      angle_next = zf[dbi_pkg::ANG_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    nx    <= x;
    ny    <= y;
    nk    <= k_next;
    nzero <= (y == '0);
    nhalf <= (x == '0);
    cx_q[0] <= dbi_pkg::CX_BITS'(nx << nk);
    cy_q[0] <= dbi_pkg::CX_BITS'(ny << nk);
    z_q[0]  <= '0;
    zf_q[0] <= nzero;
    hf_q[0] <= nhalf;
    for (int st = 0; st < dbi_pkg::CORDIC_STAGES; st++) begin
      cx_q[st+1] <= cx_next[st];
      cy_q[st+1] <= cy_next[st];
      z_q[st+1]  <= z_next[st];
      zf_q[st+1] <= zf_q[st];
      hf_q[st+1] <= hf_q[st];
    end
    angle <= angle_next;
  end

endmodule

[src/dbi_sector.sv]
// Pipeline for one corner-triangle sector: square root, two arctangents and the area and
// arc terms. One request per cycle, never stalls; depends on dbi_pkg and dbi_cordic.
module dbi_sector (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   req_valid,
  input  dbi_pkg::sec_tag_t                      req_tag,
  input  logic [dbi_pkg::COORD_BITS-1:0]         d1,
  input  logic [dbi_pkg::COORD_BITS-1:0]         d2,
  input  logic [dbi_pkg::COORD_BITS-1:0]         radius,
  input  logic [dbi_pkg::SQ_BITS-1:0]            r2,
  output logic                                   res_valid,
  output dbi_pkg::sec_tag_t                      res_tag,
  output logic [dbi_pkg::TERM_AREA_BITS-1:0]     area_term,
  output logic [dbi_pkg::TERM_ARC_BITS-1:0]      arc_term
);

  typedef struct packed {
    logic [dbi_pkg::COORD_BITS-1:0] d1;
    logic [dbi_pkg::COORD_BITS-1:0] d2;
    logic                           near;
    dbi_pkg::sec_tag_t              tag;
  } sq_side_t;

  typedef struct packed {
    logic [dbi_pkg::COORD_BITS-1:0] d1;
    logic [dbi_pkg::COORD_BITS-1:0] d2;
    logic [dbi_pkg::COORD_BITS-1:0] d3;
    logic                           case_a;
    logic                           case_b;
    dbi_pkg::sec_tag_t              tag;
  } at_side_t;

  // Input and d1 squared.
  logic                           v1, v2;
  dbi_pkg::sec_tag_t              t1, t2;
  logic [dbi_pkg::COORD_BITS-1:0] a1, b1, a2, b2;
  logic [dbi_pkg::SQ_BITS-1:0]    sq2;
  logic                           near2;

  // Square root pipeline.
  logic                        sv_vld [0:dbi_pkg::SQRT_STAGES];
  sq_side_t                    ss_q   [0:dbi_pkg::SQRT_STAGES];
  logic [dbi_pkg::SQ_BITS-1:0] sv_q   [0:dbi_pkg::SQRT_STAGES];
  logic [dbi_pkg::SQ_BITS-1:0] sr_q   [0:dbi_pkg::SQRT_STAGES];
  logic [dbi_pkg::SQ_BITS-1:0] sv_next [0:dbi_pkg::SQRT_STAGES-1];
  logic [dbi_pkg::SQ_BITS-1:0] sr_next [0:dbi_pkg::SQRT_STAGES-1];

  // Arctangent alignment.
  at_side_t                       at_side_next;
  logic                           ad_vld [0:dbi_pkg::CORDIC_LAT-1];
  at_side_t                       ad_q   [0:dbi_pkg::CORDIC_LAT-1];
  logic [dbi_pkg::ANG_BITS-1:0]   ang_a, ang_b;
  logic [dbi_pkg::COORD_BITS-1:0] sq_d3;

  // Angle difference and products.
  logic                           v5, v6, v7;
  dbi_pkg::sec_tag_t              t5, t6, t7;
  logic [dbi_pkg::ANG_BITS-1:0]   w5, w_next;
  logic [dbi_pkg::COORD_BITS-1:0] d1_5, pm5, pm_next;
  logic [dbi_pkg::SQ_BITS-1:0]    p6;
  logic [dbi_pkg::SQ_BITS-2:0]    rl6, rh6, ar6;
  logic [dbi_pkg::SQ_BITS-1:0]    q_sum;
  logic [dbi_pkg::TERM_AREA_BITS-1:0] q7;
  logic [dbi_pkg::SQ_BITS-dbi_pkg::FRAC_BITS-1:0] pf7;
  logic [dbi_pkg::TERM_ARC_BITS-1:0]  arc7;

  always_comb begin
    logic [dbi_pkg::SQ_BITS-1:0] vt, rt, bt;
    for (int st = 0; st < dbi_pkg::SQRT_STAGES; st++) begin
      vt = sv_q[st];
      rt = sr_q[st];
      for (int j = 0; j < dbi_pkg::SQRT_PER_STAGE; j++) begin
        bt = dbi_pkg::SQ_BITS'(1) <<
             (dbi_pkg::SQ_BITS - 2 - 2 * (st * dbi_pkg::SQRT_PER_STAGE + j));
        if (vt >= rt + bt) begin
          vt = vt - (rt + bt);
          rt = (rt >> 1) + bt;
        end else begin
          rt = rt >> 1;
        end
      end
      sv_next[st] = vt;
      sr_next[st] = rt;
    end
  end

  assign sq_d3 = sr_q[dbi_pkg::SQRT_STAGES][dbi_pkg::COORD_BITS-1:0];

  always_comb begin
    sq_side_t s;
    s = ss_q[dbi_pkg::SQRT_STAGES];
    at_side_next.d1     = s.d1;
    at_side_next.d2     = s.d2;
    at_side_next.d3     = sq_d3;
    at_side_next.case_a = s.near && (sq_d3 < s.d2);
    at_side_next.case_b = s.near && !(sq_d3 < s.d2);
    at_side_next.tag    = s.tag;
  end

  dbi_cordic u_atan_a (
    .clk   (clk),
    .y     (ss_q[dbi_pkg::SQRT_STAGES].d2),
    .x     (ss_q[dbi_pkg::SQRT_STAGES].d1),
    .angle (ang_a)
  );

  dbi_cordic u_atan_b (
    .clk   (clk),
    .y     (sq_d3),
    .x     (ss_q[dbi_pkg::SQRT_STAGES].d1),
    .angle (ang_b)
  );

  // The partial sector uses the angle between the chord end and the far edge; a sector that lies
  // wholly inside the circle has no arc and only the triangle area.
  always_comb begin
    at_side_t s;
    s = ad_q[dbi_pkg::CORDIC_LAT-1];
    if (s.case_b) begin
      w_next  = '0;
      pm_next = s.d2;
    end else if (s.case_a) begin
      w_next  = (ang_a > ang_b) ? ang_a - ang_b : '0;
      pm_next = s.d3;
    end else begin
      w_next  = ang_a;
      pm_next = '0;
    end
  end

  assign q_sum = dbi_pkg::SQ_BITS'(rh6) + dbi_pkg::SQ_BITS'(rl6 >> dbi_pkg::COORD_BITS);

  always_ff @(posedge clk) begin
    a1    <= d1;
    b1    <= d2;
    t1    <= req_tag;
    a2    <= a1;
    b2    <= b1;
    t2    <= t1;
    sq2   <= a1 * a1;
    near2 <= a1 < radius;

    sv_q[0]    <= near2 ? r2 - sq2 : '0;
    sr_q[0]    <= '0;
    ss_q[0].d1   <= a2;
    ss_q[0].d2   <= b2;
    ss_q[0].near <= near2;
    ss_q[0].tag  <= t2;
    for (int st = 0; st < dbi_pkg::SQRT_STAGES; st++) begin
      sv_q[st+1] <= sv_next[st];
      sr_q[st+1] <= sr_next[st];
      ss_q[st+1] <= ss_q[st];
    end

    ad_q[0] <= at_side_next;
    for (int i = 1; i < dbi_pkg::CORDIC_LAT; i++) begin
      ad_q[i] <= ad_q[i-1];
    end

    w5   <= w_next;
    pm5  <= pm_next;
    d1_5 <= ad_q[dbi_pkg::CORDIC_LAT-1].d1;
    t5   <= ad_q[dbi_pkg::CORDIC_LAT-1].tag;

    p6  <= d1_5 * pm5;
    rl6 <= r2[dbi_pkg::COORD_BITS-1:0] * w5;
    rh6 <= r2[dbi_pkg::SQ_BITS-1:dbi_pkg::COORD_BITS] * w5;
    ar6 <= w5 * radius;
    t6  <= t5;

    q7   <= dbi_pkg::TERM_AREA_BITS'(q_sum >> (dbi_pkg::ANG_FRAC + dbi_pkg::FRAC_BITS
                                               - dbi_pkg::COORD_BITS));
    pf7  <= p6[dbi_pkg::SQ_BITS-1:dbi_pkg::FRAC_BITS];
    arc7 <= dbi_pkg::TERM_ARC_BITS'(ar6 >> dbi_pkg::ANG_FRAC);
    t7   <= t6;

    area_term <= dbi_pkg::TERM_AREA_BITS'(((dbi_pkg::TERM_AREA_BITS + 1)'(pf7)
                                           + (dbi_pkg::TERM_AREA_BITS + 1)'(q7)) >> 1);
    arc_term  <= arc7;
    res_tag   <= t7;
  end

  // Valid bits are the only state that reset clears.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      for (int st = 0; st <= dbi_pkg::SQRT_STAGES; st++) begin
        sv_vld[st] <= 1'b0;
      end
      for (int i = 0; i < dbi_pkg::CORDIC_LAT; i++) begin
        ad_vld[i] <= 1'b0;
      end
      v5        <= 1'b0;
      v6        <= 1'b0;
      v7        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v1        <= req_valid;
      v2        <= v1;
      sv_vld[0] <= v2;
      for (int st = 0; st < dbi_pkg::SQRT_STAGES; st++) begin
        sv_vld[st+1] <= sv_vld[st];
      end
      ad_vld[0] <= sv_vld[dbi_pkg::SQRT_STAGES];
      for (int i = 1; i < dbi_pkg::CORDIC_LAT; i++) begin
        ad_vld[i] <= ad_vld[i-1];
      end
      v5        <= ad_vld[dbi_pkg::CORDIC_LAT-1];
      v6        <= v5;
      v7        <= v6;
      res_valid <= v7;
    end
  end

endmodule

[src/disc_box_intersection_core.sv]
// Channel   Handshake            Payload
// cfg       cfg_wen              cfg_idx, cfg_data (box edges and radius)
// in        in_valid / in_stall  in_data: point_x, point_y
// out       out_valid / out_stall out_data: area, arc_length, outside
//
// A point can be taken as its predecessor issues its last sector; its eight sectors go one per
// cycle into a single pipelined sector unit (square root, two CORDIC arctangents, products).
// Results wait in a 16-entry queue; a point is refused while the queue cannot hold it,
// so an output stall never halts the sector pipeline.
// Reset (synchronous) restores the register defaults and empties the pipeline and queue.
module disc_box_intersection_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wen,
  input  logic [dbi_pkg::CFG_IDX_BITS-1:0]     cfg_idx,
  input  logic [dbi_pkg::CFG_BITS-1:0]         cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  dbi_pkg::in_item_t                    in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output dbi_pkg::out_item_t                   out_data
);
`include "disc_box_intersection_core_defines.svh"

  logic [dbi_pkg::CFG_BITS-1:0] box_xmin, box_xmax, box_ymin, box_ymax, radius;
  logic [dbi_pkg::SQ_BITS-1:0]  r2;

  logic                           in_acc, pop;
  logic                           busy;
  logic [dbi_pkg::SEQ_BITS-1:0]   seq;
  logic [dbi_pkg::COORD_BITS-1:0] dl, dr, db, dt;
  logic                           outside;
  logic [dbi_pkg::COORD_BITS-1:0] iss_d1, iss_d2;
  dbi_pkg::sec_tag_t              iss_tag;

  logic                                   sec_vld;
  dbi_pkg::sec_tag_t                      sec_tag;
  logic [dbi_pkg::TERM_AREA_BITS-1:0]     sec_area;
  logic [dbi_pkg::TERM_ARC_BITS-1:0]      sec_arc;
  logic [dbi_pkg::ACC_AREA_BITS-1:0]      acc_area, area_sum;
  logic [dbi_pkg::ACC_ARC_BITS-1:0]       acc_arc, arc_sum;
  dbi_pkg::out_item_t                     res;

  dbi_pkg::out_item_t        fifo [0:dbi_pkg::FIFO_DEPTH-1];
  logic [dbi_pkg::FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [dbi_pkg::FIFO_AW:0]   fcnt, used;
  logic                        push;

  // Configuration registers; r2 follows radius in the next cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      box_xmin <= dbi_pkg::XMIN_RESET;
      box_xmax <= dbi_pkg::XMAX_RESET;
      box_ymin <= dbi_pkg::YMIN_RESET;
      box_ymax <= dbi_pkg::YMAX_RESET;
      radius   <= dbi_pkg::RADIUS_RESET;
    end else if (cfg_wen) begin
      case (cfg_idx)
        dbi_pkg::CFG_XMIN:   box_xmin <= cfg_data;
        dbi_pkg::CFG_XMAX:   box_xmax <= cfg_data;
        dbi_pkg::CFG_YMIN:   box_ymin <= cfg_data;
        dbi_pkg::CFG_YMAX:   box_ymax <= cfg_data;
        dbi_pkg::CFG_RADIUS: radius   <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    r2 <= radius * radius;
  end

  // Every accepted point holds one queue place from acceptance until its result is taken.
  assign in_stall = (busy && seq != dbi_pkg::SEQ_BITS'(dbi_pkg::SECTORS - 1)) ||
                    (used == (dbi_pkg::FIFO_AW + 1)'(dbi_pkg::FIFO_DEPTH));
  assign in_acc   = in_valid && !in_stall;
  assign pop      = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      seq  <= '0;
    end else if (in_acc) begin
      busy <= 1'b1;
      seq  <= '0;
    end else if (busy) begin
      seq <= seq + 1'b1;
      if (seq == dbi_pkg::SEQ_BITS'(dbi_pkg::SECTORS - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Negative edge distances are clamped to zero and flag the point as outside.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      dl <= (in_data.point_x >= box_xmin) ? in_data.point_x - box_xmin : '0;
      dr <= (box_xmax >= in_data.point_x) ? box_xmax - in_data.point_x : '0;
      db <= (in_data.point_y >= box_ymin) ? in_data.point_y - box_ymin : '0;
      dt <= (box_ymax >= in_data.point_y) ? box_ymax - in_data.point_y : '0;
      outside <= (in_data.point_x < box_xmin) || (box_xmax < in_data.point_x) ||
                 (in_data.point_y < box_ymin) || (box_ymax < in_data.point_y);
    end
  end

  always_comb begin
    case (seq)
      3'd0:    begin iss_d1 = dr; iss_d2 = dt; end
      3'd1:    begin iss_d1 = dr; iss_d2 = db; end
      3'd2:    begin iss_d1 = db; iss_d2 = dr; end
      3'd3:    begin iss_d1 = db; iss_d2 = dl; end
      3'd4:    begin iss_d1 = dl; iss_d2 = db; end
      3'd5:    begin iss_d1 = dl; iss_d2 = dt; end
      3'd6:    begin iss_d1 = dt; iss_d2 = dl; end
      default: begin iss_d1 = dt; iss_d2 = dr; end
    endcase
    iss_tag.first   = (seq == '0);
    iss_tag.last    = (seq == dbi_pkg::SEQ_BITS'(dbi_pkg::SECTORS - 1));
    iss_tag.outside = outside;
  end

  dbi_sector u_sector (
    .clk       (clk),
    .rst       (rst),
    .req_valid (busy),
    .req_tag   (iss_tag),
    .d1        (iss_d1),
    .d2        (iss_d2),
    .radius    (radius),
    .r2        (r2),
    .res_valid (sec_vld),
    .res_tag   (sec_tag),
    .area_term (sec_area),
    .arc_term  (sec_arc)
  );

  assign area_sum = (sec_tag.first ? '0 : acc_area) + dbi_pkg::ACC_AREA_BITS'(sec_area);
  assign arc_sum  = (sec_tag.first ? '0 : acc_arc) + dbi_pkg::ACC_ARC_BITS'(sec_arc);

  always_comb begin
    res.area = (|area_sum[dbi_pkg::ACC_AREA_BITS-1:dbi_pkg::AREA_BITS]) ?
               '1 : area_sum[dbi_pkg::AREA_BITS-1:0];
    res.arc_length = (|arc_sum[dbi_pkg::ACC_ARC_BITS-1:dbi_pkg::ARC_BITS]) ?
                     '1 : arc_sum[dbi_pkg::ARC_BITS-1:0];
    res.outside = sec_tag.outside;
  end

  assign push = sec_vld && sec_tag.last;

  always_ff @(posedge clk) begin
    if (sec_vld) begin
      acc_area <= area_sum;
      acc_arc  <= arc_sum;
    end
    if (push) begin
      fifo[wr_ptr] <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fcnt   <= '0;
      used   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      fcnt <= fcnt + (dbi_pkg::FIFO_AW + 1)'(push) - (dbi_pkg::FIFO_AW + 1)'(pop);
      used <= used + (dbi_pkg::FIFO_AW + 1)'(in_acc) - (dbi_pkg::FIFO_AW + 1)'(pop);
    end
  end

  assign out_valid = (fcnt != '0);
  assign out_data  = fifo[rd_ptr];

  `DBI_ASSERT_NOW(a_used_bound, 1'b1, used <= (dbi_pkg::FIFO_AW + 1)'(dbi_pkg::FIFO_DEPTH), "more points in flight than queue places")
  `DBI_ASSERT_NOW(a_queue_covered, 1'b1, fcnt <= used, "queued results exceed accepted points")
  `DBI_ASSERT_NEXT(a_push_counts, push && !pop, fcnt == $past(fcnt) + 1'b1, "result push not counted")
  `DBI_ASSERT_NEXT(a_accept_starts, in_acc, busy && seq == '0, "accepted point did not start its sectors")

endmodule
